### hdl/lpb_pkg.sv
// Shared constants, types and fade arithmetic for the LED pixel buffer.
// No dependencies.
`default_nettype none

package lpb_pkg;

  localparam int MAX_PIXELS = 256;
  localparam int SLOT_W     = $clog2(MAX_PIXELS);   // physical slot / offset width
  localparam int COUNT_W    = 9;                    // pixel_count register width
  localparam int SUM_W      = SLOT_W + 1;           // index + offset before the modulo
  localparam int FILL_W     = SLOT_W + 1;           // sweep counter, holds MAX_PIXELS
  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;

  localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FADE_SUB = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FADE_MUL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTATE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SHIFT    = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } pixel_t;

  function automatic logic [BYTE_W-1:0] fade_byte(input logic [BYTE_W-1:0] v,
                                                  input logic [BYTE_W-1:0] amount,
                                                  input logic mult);
    logic [2*BYTE_W-1:0] prod;
    prod = 16'(v) * 16'(amount);
    if (mult) begin
      fade_byte = prod[2*BYTE_W-1:BYTE_W];
    end else if (v <= amount) begin
      fade_byte = '0;
    end else begin
      fade_byte = v - amount;
    end
  endfunction

  function automatic pixel_t fade_pixel(input pixel_t p, input logic [BYTE_W-1:0] amount,
                                        input logic mult);
    pixel_t q;
    q.red   = fade_byte(p.red, amount, mult);
    q.green = fade_byte(p.green, amount, mult);
    q.blue  = fade_byte(p.blue, amount, mult);
    fade_pixel = q;
  endfunction

endpackage

`default_nettype wire

### hdl/lpb_cmd_if.sv
// Command channel: valid/ready handshake carrying one command transaction.
// Depends on lpb_pkg.
`default_nettype none

interface lpb_cmd_if import lpb_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SLOT_W-1:0]  pixel_index;
  logic [BYTE_W-1:0]  red_in;
  logic [BYTE_W-1:0]  green_in;
  logic [BYTE_W-1:0]  blue_in;
  logic [BYTE_W-1:0]  fade_amount;
  logic               direction_up;

  modport source (output valid, cmd, pixel_index, red_in, green_in, blue_in,
                  fade_amount, direction_up, input ready);
  modport sink   (input valid, cmd, pixel_index, red_in, green_in, blue_in,
                  fade_amount, direction_up, output ready);
endinterface

`default_nettype wire

### hdl/lpb_pix_if.sv
// Result channel: valid/ready handshake carrying one pixel color transaction.
// Depends on lpb_pkg.
`default_nettype none

interface lpb_pix_if import lpb_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  red_out;
  logic [BYTE_W-1:0]  green_out;
  logic [BYTE_W-1:0]  blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

### hdl/led_pixel_buffer_fade_rotate_top.sv
// LED pixel buffer with rotating offset, fades, APB count register.
// Command flow: set/get run the 9-step remainder unit, then the memory access (get adds a
// read step); shift turns the offset, then clears the vacated slot through the remainder
// unit; fades sweep the pixels in use; rotate/unused go straight to the output. One command
// in flight: command.ready is high only in S_IDLE, entered when the result is loaded out.
// Sync active-high reset: offset 0, count 256, buffer reads as zero at once (per-slot valid bits).
// Depends on lpb_pkg, lpb_cmd_if, lpb_pix_if.
`default_nettype none

module led_pixel_buffer_fade_rotate_top import lpb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB-style configuration port, register 0 = pixel_count
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  lpb_cmd_if.sink          command,
  lpb_pix_if.source        result
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_ACCESS = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FADE   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [3:0] MOD_LAST = 4'(SUM_W - 1);

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [COUNT_W-1:0] pixel_count;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(pixel_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= COUNT_W'(MAX_PIXELS);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      pixel_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Effective count: zero acts as one, above the buffer size saturates.
  logic [FILL_W-1:0] n;
  logic [FILL_W-1:0] n_m1;

  always_comb begin
    if (pixel_count == '0) begin
      n = FILL_W'(1);
    end else if (pixel_count > COUNT_W'(MAX_PIXELS)) begin
      n = FILL_W'(MAX_PIXELS);
    end else begin
      n = FILL_W'(pixel_count);
    end
    n_m1 = n - FILL_W'(1);
  end

  // ---------------------------------------------------------------
  // Command registers and control state
  // ---------------------------------------------------------------
  logic [2:0]        state;
  logic [CMD_W-1:0]  cmd_q;
  pixel_t            color_q;
  logic [BYTE_W-1:0] amount_q;
  logic              up_q;
  logic [SLOT_W-1:0] offset;
  logic [SLOT_W-1:0] offset_turned;
  pixel_t            res;

  assign command.ready = (state == S_IDLE);

  // Offset after one rotate step in the commanded direction.
  always_comb begin
    if (command.direction_up) begin
      offset_turned = (offset == '0) ? n_m1[SLOT_W-1:0] : offset - SLOT_W'(1);
    end else begin
      offset_turned = ({1'b0, offset} >= n_m1) ? '0 : offset + SLOT_W'(1);
    end
  end

  // ---------------------------------------------------------------
  // Remainder unit: (logical index + offset) mod n, one quotient bit per cycle
  // ---------------------------------------------------------------
  logic [SUM_W-1:0]  mod_num;
  logic [SLOT_W-1:0] mod_rem;
  logic [3:0]        mod_cnt;
  logic [SUM_W-1:0]  mod_trial;
  logic [SUM_W-1:0]  mod_diff;
  logic              mod_ge;

  assign mod_trial = {mod_rem, mod_num[SUM_W-1]};
  assign mod_ge    = (mod_trial >= n);
  assign mod_diff  = mod_trial - n;

  // ---------------------------------------------------------------
  // Pixel memory: one write and one registered read per cycle
  // ---------------------------------------------------------------
  pixel_t                mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] slot_valid;
  pixel_t                mem_q;
  logic                  valid_q;
  pixel_t                rd_eff;

  logic [FILL_W-1:0] fade_idx;
  logic              fade_pend;
  logic [SLOT_W-1:0] fade_waddr;
  logic              fade_issue;

  logic              we;
  logic [SLOT_W-1:0] wa;
  pixel_t            wd;
  logic [SLOT_W-1:0] ra;

  assign rd_eff     = valid_q ? mem_q : '0;
  assign fade_issue = (state == S_FADE) && (fade_idx < n);

  always_comb begin
    ra = fade_issue ? fade_idx[SLOT_W-1:0] : mod_rem;
    we = 1'b0;
    wa = mod_rem;
    wd = '0;
    if (state == S_FADE) begin
      we = fade_pend;
      wa = fade_waddr;
      wd = fade_pixel(rd_eff, amount_q, cmd_q == CMD_FADE_MUL);
    end else if (state == S_ACCESS) begin
      we = (cmd_q == CMD_SET) || (cmd_q == CMD_SHIFT);
      wd = (cmd_q == CMD_SET) ? color_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  // Slot never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (we) begin
        slot_valid[wa] <= 1'b1;
      end
      valid_q <= slot_valid[ra];
    end
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      offset       <= '0;
      fade_pend    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // S_DONE handles its own handoff of the output register
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (command.valid) begin
            cmd_q    <= command.cmd;
            color_q  <= '{red: command.red_in, green: command.green_in,
                          blue: command.blue_in};
            amount_q <= command.fade_amount;
            up_q     <= command.direction_up;
            res      <= '0;
            case (command.cmd)
              CMD_SET, CMD_GET: begin
                mod_num <= SUM_W'(command.pixel_index) + SUM_W'(offset);
                mod_rem <= '0;
                mod_cnt <= MOD_LAST;
                state   <= S_MOD;
              end
              CMD_FADE_SUB, CMD_FADE_MUL: begin
                fade_idx  <= '0;
                fade_pend <= 1'b0;
                state     <= S_FADE;
              end
              CMD_ROTATE: begin
                offset <= offset_turned;
                state  <= S_DONE;
              end
              CMD_SHIFT: begin
                offset <= offset_turned;
                state  <= S_SHIFT;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SHIFT: begin
          // vacated end: logical 0 after an up shift, logical n-1 after a down shift
          mod_num <= SUM_W'(offset) + (up_q ? '0 : n_m1);
          mod_rem <= '0;
          mod_cnt <= MOD_LAST;
          state   <= S_MOD;
        end
        S_MOD: begin
          mod_rem <= mod_ge ? mod_diff[SLOT_W-1:0] : mod_trial[SLOT_W-1:0];
          mod_num <= {mod_num[SUM_W-2:0], 1'b0};
          mod_cnt <= mod_cnt - 4'd1;
          if (mod_cnt == '0) begin
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          state <= (cmd_q == CMD_GET) ? S_READ : S_DONE;
        end
        S_READ: begin
          res   <= rd_eff;
          state <= S_DONE;
        end
        S_FADE: begin
          // read slot i while slot i-1 is written back
          fade_pend  <= fade_issue;
          fade_waddr <= fade_idx[SLOT_W-1:0];
          if (fade_issue) begin
            fade_idx <= fade_idx + FILL_W'(1);
          end else if (!fade_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid     <= 1'b1;
            result.red_out   <= res.red;
            result.green_out <= res.green;
            result.blue_out  <= res.blue;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/lpb_checker.sv
// Port-level checks for the LED pixel buffer, bound to the top level.
// Depends on led_pixel_buffer_fade_rotate_top.
`default_nettype none

module lpb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  red_out,
  input wire logic [7:0]  green_out,
  input wire logic [7:0]  blue_out,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
    else $error("result payload changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second command taken while one is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!cmd_ready))
    else $error("result produced without a command in progress");

  a_count_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2]
    |=> paddr[2] || (prdata[8:0] == $past(pwdata[8:0])))
    else $error("pixel_count readback mismatch");

endmodule

bind led_pixel_buffer_fade_rotate_top lpb_checker u_lpb_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (command.valid),
  .cmd_ready (command.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .red_out   (result.red_out),
  .green_out (result.green_out),
  .blue_out  (result.blue_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire
